/* hw/rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared sizes, status codes, register indexes and tree index helpers for the
// buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // zone size and the order it allows
  localparam int MAX_PAGES = 1024;
  localparam int MAX_ORDER = $clog2(MAX_PAGES + 1) - 1;
  localparam int DEPTH     = 2 * MAX_PAGES;

  // field and storage widths
  localparam int ORD_W  = 4;
  localparam int REQ_W  = 11;
  localparam int OFF_W  = 10;
  localparam int NODE_W = 11;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int ST_W   = 3;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 11;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [ST_W-1:0] ST_BEYOND     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_ALLOC  = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_OFFSET = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TREE_ORDER = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REAL_PAGES = 2'd1;

  // reset values of the configuration registers
  localparam logic [ORD_W-1:0]  TREE_ORDER_RST = 4'd10;
  localparam logic [CDAT_W-1:0] REAL_PAGES_RST = 11'd1024;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // log2 of the request rounded up to a power of two, zero taken as one
  function automatic logic [ORD_W-1:0] req_log2(input logic [REQ_W-1:0] req);
    logic [ORD_W-1:0] k;
    k = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (((REQ_W + 1)'(1) << i) < {1'b0, req}) begin
        k = ORD_W'(i + 1);
      end
    end
    return k;
  endfunction

  // heap index helpers
  function automatic logic [IDX_W-1:0] left_child(input logic [IDX_W-1:0] idx);
    return IDX_W'({idx, 1'b1});
  endfunction

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] idx);
    return (idx - IDX_W'(1)) >> 1;
  endfunction

  function automatic logic [IDX_W-1:0] sibling_of(input logic [IDX_W-1:0] idx);
    return idx[0] ? idx + IDX_W'(1) : idx - IDX_W'(1);
  endfunction

endpackage

/* hw/rtl/buddy_page_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Binary buddy page allocator over a heap of longest-free-run values held in
// one synchronous memory; allocate descends the tree, free climbs to the used
// node, both then repair the path to the root.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, kind, page_request,         | item in
//          | free_offset                                     |
//  out     | out_valid, out_stall, status, alloc_offset      | item out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | reg write
//
//  An allocate reads the root, then descends one tree level at a time and
//  repairs the path back up; a free climbs from the leaf to the used node
//  and then repairs the path up to the root. One memory read and one write
//  per tree level set the time it takes. A size or offset out of range, or an
//  allocate refused at the root, goes straight to the result.
//  After reset and after a write to either configuration register the tree
//  is rebuilt, one node a cycle, 2 * 2^order - 1 nodes (2047 at reset), with in_stall high.
//  A finished result waits in the output register while the next item is
//  accepted; out_stall only holds the unit when a second result is ready.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [bpa_pkg::REQ_W-1:0]    page_request,
  input  logic [bpa_pkg::OFF_W-1:0]    free_offset,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpa_pkg::ST_W-1:0]     status,
  output logic [bpa_pkg::OFF_W-1:0]    alloc_offset,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bpa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bpa_pkg::CDAT_W-1:0]   cfg_data
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_AROOT,
    S_ADOWN,
    S_FUP,
    S_UP,
    S_DONE
  } state_t;

  // control and working registers
  state_t             state, state_next;
  logic [ORD_W-1:0]   tree_order;
  logic [CDAT_W-1:0]  real_pages;
  logic [IDX_W-1:0]   sw_idx, sw_idx_next;
  logic [NODE_W-1:0]  sw_val, sw_val_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [ORD_W-1:0]   cur_log, cur_log_next;
  logic [NODE_W-1:0]  cur_val, cur_val_next;
  logic [OFF_W-1:0]   off, off_next;
  logic [ORD_W-1:0]   need_log, need_log_next;
  logic               is_free, is_free_next;
  logic [ST_W-1:0]    res_status, res_status_next;
  logic [OFF_W-1:0]   res_offset, res_offset_next;

  // tree memory
  logic [NODE_W-1:0]  mem [DEPTH];
  logic [NODE_W-1:0]  rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [NODE_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  // derived zone geometry
  logic [ORD_W-1:0]   ord_sat;
  logic [NODE_W-1:0]  tree_size;
  logic [NODE_W-1:0]  usable;
  logic [IDX_W:0]     last_node;
  logic [IDX_W-1:0]   leaf_idx;

  logic               in_fire;
  logic               cfg_fire;
  logic               out_free;

  assign ord_sat   = (tree_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : tree_order;
  assign tree_size = NODE_W'(1) << ord_sat;
  assign usable    = (real_pages < tree_size) ? real_pages : tree_size;
  assign last_node = {1'b0, tree_size} + {1'b0, tree_size} - (IDX_W + 1)'(2);
  assign leaf_idx  = IDX_W'({1'b0, free_offset} + tree_size - NODE_W'(1));

  // handshakes
  assign cfg_ready = (state == S_IDLE) || (state == S_INIT);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // next state and memory access
  always_comb begin
    logic [NODE_W-1:0]  need;
    logic [NODE_W-1:0]  init_val;
    logic [IDX_W:0]     sw_p1;
    logic [IDX_W:0]     sw_p2;
    logic [ORD_W-1:0]   ch_log;
    logic [IDX_W-1:0]   cand_idx;
    logic [OFF_W-1:0]   cand_off;
    logic [ORD_W-1:0]   cand_log;
    logic               cand_ok;
    logic [IDX_W-1:0]   par;
    logic [ORD_W-1:0]   par_log;
    logic [NODE_W-1:0]  par_size;
    logic [NODE_W:0]    pair_sum;
    logic [NODE_W-1:0]  pair_max;
    logic [NODE_W-1:0]  pval;
    logic [NODE_W-1:0]  fval;

    state_next      = state;
    sw_idx_next     = sw_idx;
    sw_val_next     = sw_val;
    idx_next        = idx;
    cur_log_next    = cur_log;
    cur_val_next    = cur_val;
    off_next        = off;
    need_log_next   = need_log;
    is_free_next    = is_free;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = '0;
    mem_raddr       = '0;

    need     = NODE_W'(1) << need_log;
    init_val = (sw_idx == '0) ? tree_size : sw_val;
    sw_p1    = {1'b0, sw_idx} + (IDX_W + 1)'(1);
    sw_p2    = {1'b0, sw_idx} + (IDX_W + 1)'(2);
    ch_log   = cur_log - ORD_W'(1);
    cand_idx = '0;
    cand_off = '0;
    cand_log = ord_sat;
    cand_ok  = 1'b0;
    par      = parent_of(idx);
    par_log  = cur_log + ORD_W'(1);
    par_size = NODE_W'(1) << par_log;
    pair_sum = {1'b0, cur_val} + {1'b0, rdata};
    pair_max = (cur_val > rdata) ? cur_val : rdata;
    pval     = (is_free && (pair_sum == {1'b0, par_size})) ? par_size : pair_max;
    fval     = NODE_W'(1) << cur_log;

    unique case (state)
      // rebuild: each node gets its subtree size
      S_INIT: begin
        mem_we      = 1'b1;
        mem_waddr   = sw_idx;
        mem_wdata   = init_val;
        sw_idx_next = sw_p1[IDX_W-1:0];
        sw_val_next = ((sw_p2 & sw_p1) == '0) ? (init_val >> 1) : init_val;
        if ({1'b0, sw_idx} == last_node) begin
          state_next = S_IDLE;
        end
      end

      // take a request, check its range, read the first node
      S_IDLE: begin
        mem_raddr = (kind == KIND_FREE) ? leaf_idx : '0;
        if (in_fire) begin
          off_next        = '0;
          res_offset_next = '0;
          if (kind == KIND_ALLOC) begin
            need_log_next = req_log2(page_request);
            is_free_next  = 1'b0;
            if (req_log2(page_request) > ord_sat) begin
              res_status_next = ST_NO_SPACE;
              state_next      = S_DONE;
            end else begin
              state_next = S_AROOT;
            end
          end else begin
            is_free_next = 1'b1;
            if ({1'b0, free_offset} >= usable) begin
              res_status_next = ST_BAD_OFFSET;
              state_next      = S_DONE;
            end else begin
              idx_next     = leaf_idx;
              cur_log_next = '0;
              state_next   = S_FUP;
            end
          end
        end
      end

      // root holds the longest free run of the whole tree
      S_AROOT: begin
        if (rdata < need) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_DONE;
        end else begin
          cand_ok = 1'b1;
        end
      end

      // one level down per cycle, left child first
      S_ADOWN: begin
        cand_log = ch_log;
        cand_ok  = 1'b1;
        if (rdata >= need) begin
          cand_idx = left_child(idx);
          cand_off = off;
        end else begin
          cand_idx = left_child(idx) + IDX_W'(1);
          cand_off = off + (OFF_W'(1) << ch_log);
        end
      end

      // climb from the leaf to the used node
      S_FUP: begin
        if (rdata == '0) begin
          mem_we    = 1'b1;
          mem_waddr = idx;
          mem_wdata = fval;
          if (idx == '0) begin
            res_status_next = ST_OK;
            res_offset_next = '0;
            state_next      = S_DONE;
          end else begin
            mem_raddr    = sibling_of(idx);
            cur_val_next = fval;
            state_next   = S_UP;
          end
        end else if (idx == '0) begin
          res_status_next = ST_NOT_ALLOC;
          res_offset_next = '0;
          state_next      = S_DONE;
        end else begin
          mem_raddr    = par;
          idx_next     = par;
          cur_log_next = par_log;
        end
      end

      // repair the path: parent from this node and its buddy
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = par;
        mem_wdata = pval;
        if (par == '0) begin
          res_status_next = ST_OK;
          res_offset_next = is_free ? '0 : off;
          state_next      = S_DONE;
        end else begin
          mem_raddr    = sibling_of(par);
          idx_next     = par;
          cur_val_next = pval;
          cur_log_next = par_log;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // allocate: node of the wanted size found, or go one level deeper
    if (cand_ok) begin
      if (cand_log == need_log) begin
        if ({1'b0, cand_off} >= usable) begin
          res_status_next = ST_BEYOND;
          res_offset_next = '0;
          state_next      = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cand_idx;
          mem_wdata = '0;
          if (cand_idx == '0) begin
            res_status_next = ST_OK;
            res_offset_next = cand_off;
            state_next      = S_DONE;
          end else begin
            mem_raddr    = sibling_of(cand_idx);
            idx_next     = cand_idx;
            off_next     = cand_off;
            cur_val_next = '0;
            cur_log_next = cand_log;
            state_next   = S_UP;
          end
        end
      end else begin
        mem_raddr    = left_child(cand_idx);
        idx_next     = cand_idx;
        off_next     = cand_off;
        cur_log_next = cand_log;
        state_next   = S_ADOWN;
      end
    end
  end

  // state, configuration and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sw_idx     <= '0;
      tree_order <= TREE_ORDER_RST;
      real_pages <= REAL_PAGES_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_TREE_ORDER: begin
            tree_order <= cfg_data[ORD_W-1:0];
            state      <= S_INIT;
            sw_idx     <= '0;
          end
          CFG_REAL_PAGES: begin
            real_pages <= cfg_data;
            state      <= S_INIT;
            sw_idx     <= '0;
          end
          default: begin
            state  <= state_next;
            sw_idx <= sw_idx_next;
          end
        endcase
      end else begin
        state  <= state_next;
        sw_idx <= sw_idx_next;
      end

      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    // working payload
    sw_val     <= sw_val_next;
    idx        <= idx_next;
    cur_log    <= cur_log_next;
    cur_val    <= cur_val_next;
    off        <= off_next;
    need_log   <= need_log_next;
    is_free    <= is_free_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;

    // result payload
    if ((state == S_DONE) && out_free) begin
      status       <= res_status;
      alloc_offset <= res_offset;
    end
  end

endmodule
